[hdl/bth_pkg.sv]
`default_nettype none

package bth_pkg;

  // Heap geometry.
  localparam int HEAP_WORDS  = 1024;
  localparam int ALIGN_BYTES = 8;

  // A split leaves a free remainder only if it can hold a header and a footer.
  localparam int MIN_SPLIT_WORDS = 2;
  // The two tag words added to every payload, in bytes.
  localparam int TAG_BYTES = 8;

  localparam int ADDR_W  = $clog2(HEAP_WORDS);
  localparam int SIZE_W  = $clog2(HEAP_WORDS + 1);
  localparam int TAG_W   = SIZE_W + 1;
  localparam int REQ_W   = 12;
  localparam int BYTES_W = 14;
  localparam int NEED_W  = BYTES_W - 2;
  localparam int CMP_W   = (SIZE_W > NEED_W) ? SIZE_W : NEED_W;

  typedef enum logic [1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } bth_op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NOFIT   = 2'd1,
    STAT_BADFREE = 2'd2
  } bth_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WR_HDR,
    S_WR_FTR,
    S_A_RD,
    S_A_CHK,
    S_F_ADDR,
    S_F_RD,
    S_F_CHK,
    S_F_NRD,
    S_F_NCHK
  } bth_state_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [REQ_W-1:0] request_bytes;
    logic [31:0]      free_address;
  } bth_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] payload_address;
  } bth_rsp_t;

  function automatic bth_rsp_t mk_rsp(bth_status_t st, logic [31:0] addr);
    bth_rsp_t r;
    r.status          = st;
    r.payload_address = addr;
    return r;
  endfunction

endpackage

`default_nettype wire

[hdl/boundary_tag_heap_allocator.sv]
// Boundary-tag heap allocator, first fit over an implicit block list, one request at a time.
// Steps: a no-op answers straight from idle; init writes one header and footer; allocate reads
// each block header in turn, then writes the whole block's tags, both halves' tags on a split,
// or reports no fit; free rejects a bad address, else walks the blocks through the target and
// reads the successor unless the block ends the heap, then writes the merged tags. The receiver
// cannot stall done. Synchronous reset writes one free block over the heap with no result beat.
`default_nettype none

module boundary_tag_heap_allocator (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output      logic             busy,
  input  wire bth_pkg::bth_req_t req,
  output      logic             done,
  output      bth_pkg::bth_rsp_t result,
  input  wire logic             cfg_we,
  input  wire logic [31:0]      cfg_wdata
);

  localparam int AW = bth_pkg::ADDR_W;
  localparam int SW = bth_pkg::SIZE_W;
  localparam int CW = bth_pkg::CMP_W;
  localparam int BW = bth_pkg::BYTES_W;
  localparam logic [SW-1:0] TOTAL_WORDS = SW'(bth_pkg::HEAP_WORDS);
  localparam logic [BW-1:0] ALIGN_M1    = BW'(bth_pkg::ALIGN_BYTES - 1);

  // Control state.
  bth_pkg::bth_state_t state, state_next;
  logic              done_next;
  logic              emit, emit_next;
  logic              pend, pend_next;
  logic [AW-1:0]     wb_hdr, wb_hdr_next;
  logic [SW-1:0]     wb_size, wb_size_next;
  logic              wb_used, wb_used_next;
  logic              has_prev, has_prev_next;
  logic [31:0]       heap_base;

  // Per-request working registers.
  bth_pkg::bth_rsp_t result_next;
  bth_pkg::bth_rsp_t res_hold, res_hold_next;
  logic [SW-1:0]     h, h_next;
  logic [CW-1:0]     need, need_next;
  logic [31:0]       fa, fa_next;
  logic [AW-1:0]     target, target_next;
  logic [AW-1:0]     prev, prev_next;
  logic [SW-1:0]     prev_size, prev_size_next;
  logic              prev_free, prev_free_next;
  logic [SW-1:0]     blk_size, blk_size_next;
  logic [AW-1:0]     pend_hdr, pend_hdr_next;
  logic [SW-1:0]     pend_size, pend_size_next;

  // Tag RAM ports.
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_waddr, ram_raddr;
  logic [bth_pkg::TAG_W-1:0] ram_wdata, ram_rdata;

  bth_ram #(
    .WIDTH (bth_pkg::TAG_W),
    .DEPTH (bth_pkg::HEAP_WORDS)
  ) u_tags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Each tag is the block size in words above an allocated bit.
  logic [SW-1:0] rd_size;
  logic          rd_used;
  assign rd_size = ram_rdata[bth_pkg::TAG_W-1:1];
  assign rd_used = ram_rdata[0];

  assign busy = (state != bth_pkg::S_IDLE);

  // Block size in words: payload plus two tags, aligned, then in words. The
  // alignment is at least a word, so the word count is a plain shift.
  logic [BW-1:0] bytes_c, rnd_c;
  logic [CW-1:0] need_c;
  assign bytes_c = BW'(req.request_bytes) + BW'(bth_pkg::TAG_BYTES);
  assign rnd_c   = (bytes_c + ALIGN_M1) & ~ALIGN_M1;
  assign need_c  = CW'(rnd_c[BW-1:2]);

  // First-fit check on the header just read.
  logic [CW-1:0] diff_c;
  logic          fit_c, split_c;
  logic [31:0]   pay_addr_c;
  assign diff_c     = CW'(rd_size) - need;
  assign fit_c      = !rd_used && (CW'(rd_size) >= need);
  assign split_c    = diff_c >= CW'(bth_pkg::MIN_SPLIT_WORDS);
  assign pay_addr_c = heap_base + ((32'(h) + 32'd1) << 2);

  // Free address decode: byte offset into the heap, then the header word index.
  logic [31:0] off_c;
  logic [29:0] tgt_c;
  logic        bad_addr_c;
  assign off_c      = fa - heap_base;
  assign tgt_c      = off_c[31:2] - 30'd1;
  assign bad_addr_c = (off_c[1:0] != 2'd0) || (off_c[31:2] == 30'd0) ||
                      (tgt_c >= 30'(bth_pkg::HEAP_WORDS));

  // Coalescing. The merged block starts at the free predecessor if there is
  // one, and takes in the successor when that one is free.
  logic [SW-1:0] nxt_c;
  logic          nxt_free_c, prev_merge_c;
  logic [SW-1:0] merge_size_c;
  logic [AW-1:0] merge_hdr_c;
  assign nxt_c        = SW'(target) + blk_size;
  assign nxt_free_c   = (state == bth_pkg::S_F_NCHK) && !rd_used && (rd_size != '0);
  assign prev_merge_c = has_prev && prev_free;
  assign merge_size_c = blk_size + (nxt_free_c ? rd_size : '0) +
                        (prev_merge_c ? prev_size : '0);
  assign merge_hdr_c  = prev_merge_c ? prev : target;

  logic [SW-1:0] ftr_c;
  assign ftr_c = SW'(wb_hdr) + wb_size - SW'(1);

  always_comb begin
    state_next     = state;
    done_next      = 1'b0;
    result_next    = result;
    emit_next      = emit;
    pend_next      = pend;
    wb_hdr_next    = wb_hdr;
    wb_size_next   = wb_size;
    wb_used_next   = wb_used;
    has_prev_next  = has_prev;
    res_hold_next  = res_hold;
    h_next         = h;
    need_next      = need;
    fa_next        = fa;
    target_next    = target;
    prev_next      = prev;
    prev_size_next = prev_size;
    prev_free_next = prev_free;
    blk_size_next  = blk_size;
    pend_hdr_next  = pend_hdr;
    pend_size_next = pend_size;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;

    case (state)
      bth_pkg::S_IDLE: begin
        if (start) begin
          need_next = need_c;
          fa_next   = req.free_address;
          case (req.opcode)
            bth_pkg::OP_INIT: begin
              wb_hdr_next   = '0;
              wb_size_next  = TOTAL_WORDS;
              wb_used_next  = 1'b0;
              pend_next     = 1'b0;
              emit_next     = 1'b1;
              res_hold_next = bth_pkg::mk_rsp(bth_pkg::STAT_OK, 32'd0);
              state_next    = bth_pkg::S_WR_HDR;
            end
            bth_pkg::OP_ALLOC: begin
              h_next     = '0;
              state_next = bth_pkg::S_A_RD;
            end
            bth_pkg::OP_FREE: begin
              state_next = bth_pkg::S_F_ADDR;
            end
            default: begin
              done_next   = 1'b1;
              result_next = bth_pkg::mk_rsp(bth_pkg::STAT_OK, 32'd0);
            end
          endcase
        end
      end

      bth_pkg::S_WR_HDR: begin
        ram_we     = 1'b1;
        ram_waddr  = wb_hdr;
        ram_wdata  = {wb_size, wb_used};
        state_next = bth_pkg::S_WR_FTR;
      end

      bth_pkg::S_WR_FTR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ftr_c);
        ram_wdata = {wb_size, wb_used};
        if (pend) begin
          wb_hdr_next  = pend_hdr;
          wb_size_next = pend_size;
          wb_used_next = 1'b0;
          pend_next    = 1'b0;
          state_next   = bth_pkg::S_WR_HDR;
        end else begin
          done_next   = emit;
          result_next = res_hold;
          state_next  = bth_pkg::S_IDLE;
        end
      end

      bth_pkg::S_A_RD: begin
        if (h >= TOTAL_WORDS) begin
          done_next   = 1'b1;
          result_next = bth_pkg::mk_rsp(bth_pkg::STAT_NOFIT, 32'd0);
          state_next  = bth_pkg::S_IDLE;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = AW'(h);
          state_next = bth_pkg::S_A_CHK;
        end
      end

      bth_pkg::S_A_CHK: begin
        if (rd_size == '0) begin
          done_next   = 1'b1;
          result_next = bth_pkg::mk_rsp(bth_pkg::STAT_NOFIT, 32'd0);
          state_next  = bth_pkg::S_IDLE;
        end else if (fit_c) begin
          res_hold_next = bth_pkg::mk_rsp(bth_pkg::STAT_OK, pay_addr_c);
          emit_next     = 1'b1;
          wb_hdr_next   = AW'(h);
          wb_used_next  = 1'b1;
          if (split_c) begin
            wb_size_next   = SW'(need);
            pend_next      = 1'b1;
            pend_hdr_next  = AW'(h + SW'(need));
            pend_size_next = SW'(diff_c);
          end else begin
            wb_size_next = rd_size;
            pend_next    = 1'b0;
          end
          state_next = bth_pkg::S_WR_HDR;
        end else begin
          h_next     = h + rd_size;
          state_next = bth_pkg::S_A_RD;
        end
      end

      bth_pkg::S_F_ADDR: begin
        if (bad_addr_c) begin
          done_next   = 1'b1;
          result_next = bth_pkg::mk_rsp(bth_pkg::STAT_BADFREE, 32'd0);
          state_next  = bth_pkg::S_IDLE;
        end else begin
          target_next   = AW'(tgt_c);
          h_next        = '0;
          has_prev_next = 1'b0;
          state_next    = bth_pkg::S_F_RD;
        end
      end

      bth_pkg::S_F_RD: begin
        if (h >= TOTAL_WORDS) begin
          done_next   = 1'b1;
          result_next = bth_pkg::mk_rsp(bth_pkg::STAT_BADFREE, 32'd0);
          state_next  = bth_pkg::S_IDLE;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = AW'(h);
          state_next = bth_pkg::S_F_CHK;
        end
      end

      bth_pkg::S_F_CHK: begin
        if (rd_size == '0 || h > SW'(target) || (h == SW'(target) && !rd_used)) begin
          done_next   = 1'b1;
          result_next = bth_pkg::mk_rsp(bth_pkg::STAT_BADFREE, 32'd0);
          state_next  = bth_pkg::S_IDLE;
        end else if (h == SW'(target)) begin
          blk_size_next = rd_size;
          state_next    = bth_pkg::S_F_NRD;
        end else begin
          // Remember the predecessor's tag so the merge needs no second read.
          prev_next      = AW'(h);
          prev_size_next = rd_size;
          prev_free_next = !rd_used;
          has_prev_next  = 1'b1;
          h_next         = h + rd_size;
          state_next     = bth_pkg::S_F_RD;
        end
      end

      bth_pkg::S_F_NRD: begin
        if (nxt_c < TOTAL_WORDS) begin
          ram_re     = 1'b1;
          ram_raddr  = AW'(nxt_c);
          state_next = bth_pkg::S_F_NCHK;
        end else begin
          wb_hdr_next   = merge_hdr_c;
          wb_size_next  = merge_size_c;
          wb_used_next  = 1'b0;
          pend_next     = 1'b0;
          emit_next     = 1'b1;
          res_hold_next = bth_pkg::mk_rsp(bth_pkg::STAT_OK, 32'd0);
          state_next    = bth_pkg::S_WR_HDR;
        end
      end

      bth_pkg::S_F_NCHK: begin
        wb_hdr_next   = merge_hdr_c;
        wb_size_next  = merge_size_c;
        wb_used_next  = 1'b0;
        pend_next     = 1'b0;
        emit_next     = 1'b1;
        res_hold_next = bth_pkg::mk_rsp(bth_pkg::STAT_OK, 32'd0);
        state_next    = bth_pkg::S_WR_HDR;
      end

      default: begin
        state_next = bth_pkg::S_IDLE;
      end
    endcase
  end

  // Reset writes the initial free block through the normal tag write path,
  // without a result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bth_pkg::S_WR_HDR;
      done      <= 1'b0;
      emit      <= 1'b0;
      pend      <= 1'b0;
      wb_hdr    <= '0;
      wb_size   <= TOTAL_WORDS;
      wb_used   <= 1'b0;
      has_prev  <= 1'b0;
      heap_base <= 32'd0;
    end else begin
      state    <= state_next;
      done     <= done_next;
      emit     <= emit_next;
      pend     <= pend_next;
      wb_hdr   <= wb_hdr_next;
      wb_size  <= wb_size_next;
      wb_used  <= wb_used_next;
      has_prev <= has_prev_next;
      if (cfg_we) begin
        heap_base <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    result    <= result_next;
    res_hold  <= res_hold_next;
    h         <= h_next;
    need      <= need_next;
    fa        <= fa_next;
    target    <= target_next;
    prev      <= prev_next;
    prev_size <= prev_size_next;
    prev_free <= prev_free_next;
    blk_size  <= blk_size_next;
    pend_hdr  <= pend_hdr_next;
    pend_size <= pend_size_next;
  end

  // Reads and writes of the tag RAM never share a cycle, so no forwarding is needed.
  a_no_rw_overlap: assert property (@(posedge clk) !(ram_we && ram_re))
    else $error("tag RAM read and write in the same cycle");

  // Tags are only written while a request (or the reset init) is in flight.
  a_write_busy: assert property (@(posedge clk) ram_we |-> busy)
    else $error("tag write while idle");

  // Reset always starts the heap init sequence.
  a_reset_init: assert property (@(posedge clk) rst |=> busy)
    else $error("reset did not start heap init");

  // Every accepted request other than the no-op occupies the block.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && req.opcode != bth_pkg::OP_NOP) |=> busy)
    else $error("accepted request did not start");

  // A failed request never reports an address.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != bth_pkg::STAT_OK) |-> (result.payload_address == 32'd0))
    else $error("nonzero address on failed request");

endmodule

`default_nettype wire

[hdl/bth_ram.sv]
`default_nettype none

module bth_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
